// ----- hw/rtl/pidg_pkg.sv -----
// Shared types, widths, codes and a helper function of the PID step block.
package pidg_pkg;

    localparam int DATA_W    = 32;
    localparam int GAIN_W    = 16;
    localparam int ERR_W     = 17;
    localparam int SUM_W     = 33;
    localparam int DIFF_W    = 18;
    localparam int DP_W      = 34;
    localparam int PROD_W    = 48;
    localparam int SAT_W     = PROD_W + 2;
    localparam int DECI      = 10;
    localparam int QDEPTH    = 4;
    localparam int CDIV_LAT  = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd3;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    typedef struct packed {
        logic                     op;
        logic signed [DATA_W-1:0] val;
    } t_entry;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
    } t_gains;

    typedef struct packed {
        logic                     op;
        logic signed [DATA_W-1:0] sum;
    } t_side;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic [SAT_W-DATA_W:0] top;
        top = v[SAT_W-1:DATA_W-1];
        if (top == '0 || top == '1) begin
            return v[DATA_W-1:0];
        end else if (v[SAT_W-1]) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

endpackage

// ----- hw/rtl/pidg_if.sv -----
// Valid/ready channel interfaces for input items and result items.
interface pidg_in_if import pidg_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic signed [GAIN_W-1:0] sample;
    logic signed [DATA_W-1:0] preload;

    modport source (output valid, output op, output sample, output preload, input ready);
    modport sink   (input valid, input op, input sample, input preload, output ready);
endinterface

interface pidg_out_if import pidg_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] drive;
    logic signed [DATA_W-1:0] error_sum;

    modport source (output valid, output drive, output error_sum, input ready);
    modport sink   (input valid, input drive, input error_sum, output ready);
endinterface

// ----- hw/rtl/pidg_front.sv -----
// Front end: accepts items, forms the error and classifies them for the queue.
module pidg_front import pidg_pkg::*; (
    pidg_in_if.sink                  i_in,
    input  logic signed [GAIN_W-1:0] i_target,
    input  logic                     i_push_ready,
    output logic                     o_push_valid,
    output t_entry                   o_push_data
);

    logic signed [ERR_W-1:0] err;

    assign err          = ERR_W'(i_target) - ERR_W'(i_in.sample);
    assign o_push_valid = i_in.valid;
    assign i_in.ready   = i_push_ready;

    always_comb begin
        o_push_data.op = i_in.op;
        unique case (i_in.op)
            OP_LOAD: o_push_data.val = i_in.preload;
            default: o_push_data.val = DATA_W'(err);
        endcase
    end

endmodule

// ----- hw/rtl/pidg_fifo.sv -----
// Short queue between the front end and the back end.
module pidg_fifo import pidg_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_valid,
    output logic   o_push_ready,
    input  t_entry i_push_data,
    output logic   o_pop_valid,
    input  logic   i_pop_ready,
    output t_entry o_pop_data
);

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_entry             r_mem [QDEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_count != CNT_W'(QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count + CNT_W'(push) - CNT_W'(pop);
        if (push) begin
            n_wr = (r_wr == PTR_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == PTR_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QDEPTH))
        else $error("queue fill count beyond depth");

    a_count_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue fill count did not advance on push");

    a_count_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !push |=> r_count == $past(r_count) - 1'b1)
        else $error("queue fill count did not drop on pop");

endmodule

// ----- hw/rtl/pidg_cdiv.sv -----
// Pipelined signed division by a constant, truncating toward zero.
module pidg_cdiv import pidg_pkg::*; #(
    parameter int DIVISOR = 10
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [PROD_W-1:0] i_x,
    output logic signed [PROD_W-1:0] o_q
);

    localparam int W     = PROD_W;
    localparam int HW    = W / 2;
    localparam int MW    = W + 1;
    localparam int K     = W + $clog2(DIVISOR);
    localparam int FW    = K + W;
    localparam int LL_W  = 2 * HW;
    localparam int MID_W = MW + 1;
    localparam logic [127:0] M_FULL =
        ((128'd1 << K) + 128'(DIVISOR) - 128'd1) / 128'(DIVISOR);
    localparam logic [HW-1:0]    M_LO = M_FULL[HW-1:0];
    localparam logic [MW-HW-1:0] M_HI = M_FULL[MW-1:HW];

    logic [W-1:0]     r_mag;
    logic             r_sgn_a, r_sgn_b, r_sgn_c, r_sgn_d;
    logic [LL_W-1:0]  r_ll, r_hl, r_ll_c;
    logic [MW-1:0]    r_lh, r_hh, r_hh_c;
    logic [MID_W-1:0] r_mid;
    logic [FW-1:0]    full;
    logic [W-1:0]     r_qm;
    logic signed [W-1:0] r_q;

    assign full = FW'(r_ll_c) + (FW'(r_mid) << HW) + (FW'(r_hh_c) << (2 * HW));
    assign o_q  = r_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sgn_a <= i_x[W-1];
            r_mag   <= i_x[W-1] ? W'(-i_x) : W'(i_x);

            r_sgn_b <= r_sgn_a;
            r_ll    <= LL_W'(r_mag[HW-1:0]) * LL_W'(M_LO);
            r_lh    <= MW'(r_mag[HW-1:0]) * MW'(M_HI);
            r_hl    <= LL_W'(r_mag[W-1:HW]) * LL_W'(M_LO);
            r_hh    <= MW'(r_mag[W-1:HW]) * MW'(M_HI);

            r_sgn_c <= r_sgn_b;
            r_mid   <= MID_W'(r_lh) + MID_W'(r_hl);
            r_ll_c  <= r_ll;
            r_hh_c  <= r_hh;

            r_sgn_d <= r_sgn_c;
            r_qm    <= full[K +: W];

            r_q     <= r_sgn_d ? -$signed(r_qm) : $signed(r_qm);
        end
    end

endmodule

// ----- hw/rtl/pidg_back.sv -----
// Back end: state update, gain products, divisions and the output register.
module pidg_back import pidg_pkg::*; #(
    parameter int RATE = 100
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_gains i_gains,
    input  logic   i_pop_valid,
    output logic   o_pop_ready,
    input  t_entry i_pop_data,
    pidg_out_if.source o_out
);

    localparam int LAT   = CDIV_LAT;
    localparam int DIV_I = DECI * RATE;
    localparam logic signed [PROD_W-1:0] RATE_S = PROD_W'(RATE);

    logic                     en;
    logic                     take;
    logic signed [ERR_W-1:0]  e_in;
    logic signed [SUM_W-1:0]  s_in;
    logic signed [DIFF_W-1:0] diff_in;
    logic signed [DATA_W-1:0] n_sum;

    logic signed [DATA_W-1:0] r_sum;
    logic signed [ERR_W-1:0]  r_last_err;

    logic                     r_v1, r_v2, r_v3;
    logic                     r1_op, r2_op, r3_op;
    logic signed [ERR_W-1:0]  r1_e;
    logic signed [SUM_W-1:0]  r1_s;
    logic signed [DIFF_W-1:0] r1_diff;
    logic signed [DATA_W-1:0] r1_sum, r2_sum, r3_sum;
    logic signed [PROD_W-1:0] r2_pp, r2_ip, r3_pp, r3_ip, r3_dd;
    logic signed [DP_W-1:0]   r2_dp;

    logic signed [PROD_W-1:0] q_p, q_i, q_d;
    t_side                    r_side [LAT];
    logic [LAT-1:0]           r_vd;

    logic signed [DATA_W-1:0] n_drive;
    logic signed [DATA_W-1:0] r_last_drive;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_drive;
    logic signed [DATA_W-1:0] r_out_sum;

    assign en          = !r_out_valid || o_out.ready;
    assign o_pop_ready = en;
    assign take        = en && i_pop_valid;

    assign e_in    = i_pop_data.val[ERR_W-1:0];
    assign s_in    = SUM_W'(r_sum) + SUM_W'(e_in);
    assign diff_in = DIFF_W'(e_in) - DIFF_W'(r_last_err);

    always_comb begin
        if (i_pop_data.op == OP_LOAD) begin
            n_sum = i_pop_data.val;
        end else begin
            n_sum = sat32(SAT_W'(s_in));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_last_err <= '0;
        end else if (take) begin
            r_sum <= n_sum;
            if (i_pop_data.op == OP_SAMPLE) begin
                r_last_err <= e_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vd <= '0;
        end else if (en) begin
            r_v1 <= i_pop_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_vd <= {r_vd[LAT-2:0], r_v3};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op   <= i_pop_data.op;
            r1_e    <= e_in;
            r1_s    <= s_in;
            r1_diff <= diff_in;
            r1_sum  <= n_sum;

            r2_op   <= r1_op;
            r2_sum  <= r1_sum;
            r2_pp   <= PROD_W'(i_gains.gain_p) * PROD_W'(r1_e);
            r2_ip   <= PROD_W'(i_gains.gain_i) * PROD_W'(r1_s);
            r2_dp   <= DP_W'(i_gains.gain_d) * DP_W'(r1_diff);

            r3_op   <= r2_op;
            r3_sum  <= r2_sum;
            r3_pp   <= r2_pp;
            r3_ip   <= r2_ip;
            r3_dd   <= PROD_W'(r2_dp) * RATE_S;

            r_side[0] <= '{op: r3_op, sum: r3_sum};
            for (int k = 1; k < LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    pidg_cdiv #(.DIVISOR(DECI)) u_div_p (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r3_pp),
        .o_q   (q_p)
    );

    pidg_cdiv #(.DIVISOR(DIV_I)) u_div_i (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r3_ip),
        .o_q   (q_i)
    );

    pidg_cdiv #(.DIVISOR(DECI)) u_div_d (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r3_dd),
        .o_q   (q_d)
    );

    always_comb begin
        if (r_side[LAT-1].op == OP_LOAD) begin
            n_drive = r_last_drive;
        end else begin
            n_drive = sat32(SAT_W'(q_p) + SAT_W'(q_i) + SAT_W'(q_d));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_last_drive <= '0;
        end else if (en) begin
            r_out_valid <= r_vd[LAT-1];
            if (r_vd[LAT-1] && r_side[LAT-1].op == OP_SAMPLE) begin
                r_last_drive <= n_drive;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_drive <= n_drive;
            r_out_sum   <= r_side[LAT-1].sum;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.drive     = r_out_drive;
    assign o_out.error_sum = r_out_sum;

    a_load_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_pop_data.op == OP_LOAD |=> r_sum == $past(i_pop_data.val))
        else $error("integrated error not loaded");

    a_sample_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_pop_data.op == OP_SAMPLE |=> r_last_err == $past(e_in))
        else $error("previous error not updated");

    a_load_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_vd[LAT-1] && r_side[LAT-1].op == OP_LOAD
            |=> r_out_drive == $past(r_last_drive))
        else $error("load item did not repeat the last drive");

endmodule

// ----- hw/rtl/pid_controller_deci_gain_core.sv -----
// PID step with gains in tenths: top level with configuration registers.
//
// Usage:
//   i_in  carries items: op = 0 processes a sensor sample, op = 1 loads the
//         integrated error from preload. One transfer per item.
//   o_out carries one result per item: saturated drive and the error sum.
//   The configuration port writes gain_p, gain_i, gain_d and target by index;
//   the user must write only while the block holds no items in flight, unchecked by the block itself.
// Timing:
//   Throughput is one item per cycle while o_out is ready. A result passes,
//   after its input transfer, through queue, state update, gain products, rate
//   product, five stages of the reciprocal dividers and the output register.
// Reset:
//   Gains, target, integrated error, previous error and last drive clear to
//   zero; the queue and all pipeline stages empty.
// Backpressure:
//   When o_out is not ready the back end holds; the four-entry queue keeps
//   i_in ready until it fills.
module pid_controller_deci_gain_core import pidg_pkg::*; #(
    parameter int RATE_HZ = 100
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [GAIN_W-1:0]        i_cfg_data,
    pidg_in_if.sink                  i_in,
    pidg_out_if.source               o_out
);

    localparam int RATE_EFF = (RATE_HZ < 1) ? 1 : RATE_HZ;

    t_gains                   r_gains;
    logic signed [GAIN_W-1:0] r_target;

    logic   push_valid;
    logic   push_ready;
    t_entry push_data;
    logic   pop_valid;
    logic   pop_ready;
    t_entry pop_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains  <= '0;
            r_target <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GAIN_P: r_gains.gain_p <= i_cfg_data;
                CFG_GAIN_I: r_gains.gain_i <= i_cfg_data;
                CFG_GAIN_D: r_gains.gain_d <= i_cfg_data;
                CFG_TARGET: r_target       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    pidg_front u_front (
        .i_in         (i_in),
        .i_target     (r_target),
        .i_push_ready (push_ready),
        .o_push_valid (push_valid),
        .o_push_data  (push_data)
    );

    pidg_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    pidg_back #(.RATE(RATE_EFF)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_gains     (r_gains),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_out       (o_out)
    );

endmodule

// ----- tb/pid_controller_deci_gain_core_tb.sv -----
// Self-checking testbench for the PID step core with gains in tenths.
`timescale 1ns / 1ps

module pid_controller_deci_gain_core_tb;
    import pidg_pkg::*;

    localparam int RATE_HZ     = 100;
    localparam int CYCLE_LIMIT = 100000;
    localparam int PHASE_ITEMS = 240;
    localparam int RAND_PHASES = 8;

    typedef struct {
        logic                     op;
        logic signed [GAIN_W-1:0] sample;
        logic signed [DATA_W-1:0] preload;
    } t_pid_item;

    typedef struct {
        logic signed [DATA_W-1:0] drive;
        logic signed [DATA_W-1:0] error_sum;
    } t_pid_out;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = CFG_GAIN_P;
    logic [GAIN_W-1:0]    cfg_data = '0;

    pidg_in_if  in_ch ();
    pidg_out_if out_ch ();

    pid_controller_deci_gain_core #(.RATE_HZ(RATE_HZ)) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_in      (in_ch),
        .o_out     (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // controller state as the core should hold it
    logic signed [GAIN_W-1:0] kp_q = '0;
    logic signed [GAIN_W-1:0] ki_q = '0;
    logic signed [GAIN_W-1:0] kd_q = '0;
    logic signed [GAIN_W-1:0] setpoint_q = '0;
    logic signed [ERR_W-1:0]  prev_err_q = '0;
    logic signed [DATA_W-1:0] err_sum_q = '0;
    logic signed [DATA_W-1:0] drive_q = '0;

    t_pid_item pending_items[$];
    t_pid_out  pid_results_due[$];
    t_pid_item on_bus;
    logic      quiet = 1'b0;
    int        errors = 0;
    int        n_samples = 0;
    int        n_loads = 0;
    int        n_checked = 0;
    int        n_settings = 0;
    int        cycles = 0;

    function automatic logic signed [DATA_W-1:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[DATA_W-1:0];
    endfunction

    function automatic t_pid_out pid_step_predict(input t_pid_item it);
        longint   e;
        longint   p_term;
        longint   i_term;
        longint   d_term;
        longint   rate;
        t_pid_out r;
        rate = (RATE_HZ < 1) ? 1 : RATE_HZ;
        if (it.op == OP_LOAD) begin
            err_sum_q = it.preload;
        end else begin
            e      = longint'(setpoint_q) - longint'(it.sample);
            p_term = (longint'(kp_q) * e) / DECI;
            i_term = ((longint'(ki_q) * (longint'(err_sum_q) + e)) / rate) / DECI;
            d_term = (longint'(kd_q) * (e - longint'(prev_err_q)) * rate) / DECI;
            drive_q    = clamp32(p_term + i_term + d_term);
            prev_err_q = e[ERR_W-1:0];
            err_sum_q  = clamp32(longint'(err_sum_q) + e);
        end
        r.drive     = drive_q;
        r.error_sum = err_sum_q;
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // driver: track register writes, predict on each transfer, present the next item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_GAIN_P: kp_q = cfg_data;
                    CFG_GAIN_I: ki_q = cfg_data;
                    CFG_GAIN_D: kd_q = cfg_data;
                    CFG_TARGET: setpoint_q = cfg_data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                pid_results_due.push_back(pid_step_predict(on_bus));
                if (on_bus.op == OP_LOAD) n_loads++;
                else n_samples++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_items.size() != 0 && (quiet || $urandom_range(0, 99) >= 8)) begin
                    on_bus = pending_items.pop_front();
                    in_ch.op      <= on_bus.op;
                    in_ch.sample  <= on_bus.sample;
                    in_ch.preload <= on_bus.preload;
                    in_ch.valid   <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_pid_out want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pid_results_due.size() == 0) begin
                    $error("unexpected result: drive %0d error_sum %0d",
                           out_ch.drive, out_ch.error_sum);
                    errors++;
                end else begin
                    want = pid_results_due.pop_front();
                    n_checked++;
                    if (out_ch.drive !== want.drive) begin
                        $error("drive: expected %0d, actual %0d", want.drive, out_ch.drive);
                        errors++;
                    end
                    if (out_ch.error_sum !== want.error_sum) begin
                        $error("error_sum: expected %0d, actual %0d",
                               want.error_sum, out_ch.error_sum);
                        errors++;
                    end
                end
            end
            out_ch.ready <= quiet || ($urandom_range(0, 99) >= 8);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_gains(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                             input logic [GAIN_W-1:0] d, input logic [GAIN_W-1:0] sp);
        write_reg(CFG_GAIN_P, p);
        write_reg(CFG_GAIN_I, i);
        write_reg(CFG_GAIN_D, d);
        write_reg(CFG_TARGET, sp);
        n_settings++;
    endtask

    task automatic add_sample(input logic signed [GAIN_W-1:0] s);
        t_pid_item it;
        it.op      = OP_SAMPLE;
        it.sample  = s;
        it.preload = $urandom;
        pending_items.push_back(it);
    endtask

    task automatic add_load(input logic signed [DATA_W-1:0] v);
        t_pid_item it;
        it.op      = OP_LOAD;
        it.sample  = GAIN_W'($urandom);
        it.preload = v;
        pending_items.push_back(it);
    endtask

    // hold until the core has returned every outstanding result
    task automatic drain();
        @(negedge i_clk);
        while (pending_items.size() != 0 || in_ch.valid || pid_results_due.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 3))
            0: return GAIN_W'($urandom);
            1: return GAIN_W'(int'($urandom_range(0, 100)) - 50);
            2: return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
            default: return GAIN_W'(int'($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    initial begin
        logic [GAIN_W-1:0]        sp;
        logic signed [DATA_W-1:0] pre;
        in_ch.valid   = 1'b0;
        in_ch.op      = OP_SAMPLE;
        in_ch.sample  = '0;
        in_ch.preload = '0;
        out_ch.ready  = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset gains: drive stays zero, sum follows
        add_sample(16'sh7fff);
        add_sample(16'sh8000);
        add_load(32'sh7fffffff);
        drain();

        set_gains(16'd12, 16'd5, 16'd3, 16'd100);
        add_sample(16'sd0);
        add_sample(16'sd100);
        add_sample(16'sh8000);
        add_sample(16'sh7fff);
        add_load(32'sh7fffff00);
        add_sample(16'sh8000);
        add_load(32'sh80000000);
        add_sample(16'sh7fff);
        drain();

        set_gains(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        add_sample(16'sh8000);
        add_sample(16'sh8000);
        add_load(32'sh7fffffff);
        add_sample(16'sh8000);
        drain();

        set_gains(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        add_sample(16'sh7fff);
        add_sample(16'sh7fff);
        add_load(32'sh80000000);
        add_sample(16'sh7fff);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            sp = pick_gain();
            set_gains(pick_gain(), pick_gain(), pick_gain(), sp);
            quiet = (ph == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 10) begin
                    case ($urandom_range(0, 3))
                        0: pre = $urandom;
                        1: pre = 32'sh7fffffff - int'($urandom_range(0, 200));
                        2: pre = 32'sh80000000 + int'($urandom_range(0, 200));
                        default: pre = int'($urandom_range(0, 2000)) - 1000;
                    endcase
                    add_load(pre);
                end else begin
                    case ($urandom_range(0, 3))
                        0, 1: add_sample(GAIN_W'($urandom));
                        2: add_sample(sp + GAIN_W'(int'($urandom_range(0, 40)) - 20));
                        default: add_sample(($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000);
                    endcase
                end
            end
            drain();
            quiet = 1'b0;
        end

        repeat (12) @(posedge i_clk);
        $display("Covered %0d sample and %0d load transfers across %0d gain settings,",
                 n_samples, n_loads, n_settings);
        $display("with %0d results compared and %0d mismatches.", n_checked, errors);
        if (errors == 0 && pid_results_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
